// File: design/ufpc_pkg.sv
`timescale 1ns / 1ps

package ufpc_pkg;

    localparam int NODES_DEFAULT = 1024;

    // fixed field widths of the item channels
    localparam int NODE_W = 10;
    localparam int SIZE_W = 11;

    localparam int SIZE_OUT_MAX = 2047;

    localparam logic KIND_FIND  = 1'b0;
    localparam logic KIND_MERGE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_FSTART,
        ST_WALK,
        ST_COMP,
        ST_FDONE,
        ST_MHI,
        ST_MADD,
        ST_SZWAIT,
        ST_RESULT
    } ufpc_state_t;

endpackage

// File: design/ufpc_in_if.sv
`timescale 1ns / 1ps

interface ufpc_in_if import ufpc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;

    modport source (output valid, output kind, output node_a, output node_b, input ready);
    modport sink   (input valid, input kind, input node_a, input node_b, output ready);
endinterface

// File: design/ufpc_out_if.sv
`timescale 1ns / 1ps

interface ufpc_out_if import ufpc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] root;
    logic              joined;
    logic [SIZE_W-1:0] set_size;

    modport source (output valid, output root, output joined, output set_size, input ready);
    modport sink   (input valid, input root, input joined, input set_size, output ready);
endinterface

// File: design/ufpc_ram.sv
`timescale 1ns / 1ps

module ufpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: design/union_find_path_compression.sv
`timescale 1ns / 1ps
// A merge of two nodes that already share a root skips the join and reports that root.
// One item at a time: the next item is taken in the cycle after the current one moves
// into the output register.
// Reset: rst_n clears control at once; a clearing pass over all NODES entries then fills both tables.

module union_find_path_compression import ufpc_pkg::*; #(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    ufpc_in_if.sink    req,
    ufpc_out_if.source rsp
);

    localparam int IW = $clog2(NODES);
    localparam int SW = $clog2(NODES + 1);
    localparam int RW = (IW > NODE_W) ? IW : NODE_W;
    localparam int EW = (SW > SIZE_W) ? SW : SIZE_W;
    localparam bit NEED_MOD = (NODES < (1 << NODE_W));
    localparam int RECIP_SHIFT = 2 * NODE_W;
    localparam int RECIP = ((1 << RECIP_SHIFT) + NODES - 1) / NODES;
    localparam int PW = NODE_W + RECIP_SHIFT + 1;

    ufpc_state_t state_reg, state_next;

    logic [IW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;

    logic              kind_reg, kind_next;
    logic [NODE_W-1:0] raw_a_reg, raw_a_next;
    logic [NODE_W-1:0] raw_b_reg, raw_b_next;
    logic [NODE_W-1:0] qa_reg, qa_next;
    logic [NODE_W-1:0] qb_reg, qb_next;
    logic [IW-1:0]     idx_b_reg, idx_b_next;
    logic [IW-1:0]     start_reg, start_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [IW-1:0]     rt_reg, rt_next;
    logic [IW-1:0]     ra_reg, ra_next;
    logic              phase_b_reg, phase_b_next;
    logic [IW-1:0]     hi_reg, hi_next;
    logic [SW-1:0]     lo_size_reg, lo_size_next;
    logic [IW-1:0]     res_root_reg, res_root_next;
    logic              res_joined_reg, res_joined_next;
    logic [SW-1:0]     res_size_reg, res_size_next;
    logic [NODE_W-1:0] out_root_reg, out_root_next;
    logic              out_joined_reg, out_joined_next;
    logic [SIZE_W-1:0] out_size_reg, out_size_next;

    logic              p_we;
    logic [IW-1:0]     p_waddr, p_wdata, p_raddr, p_rdata;
    logic              s_we;
    logic [IW-1:0]     s_waddr, s_raddr;
    logic [SW-1:0]     s_wdata, s_rdata;

    logic              accept;
    logic              out_free;
    logic [PW-1:0]     mul_a, mul_b;
    logic [2*NODE_W-1:0] qd_a, qd_b;
    logic [NODE_W-1:0] rem_a, rem_b;
    logic [SW-1:0]     size_sum;
    logic [RW-1:0]     root_ext;
    logic [EW-1:0]     size_ext;

    ufpc_ram #(.WIDTH(IW), .DEPTH(NODES)) u_parent_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    ufpc_ram #(.WIDTH(SW), .DEPTH(NODES)) u_size_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid    = out_valid_reg;
    assign rsp.root     = out_root_reg;
    assign rsp.joined   = out_joined_reg;
    assign rsp.set_size = out_size_reg;

    // index reduction: quotient by reciprocal multiply, remainder in the next cycle
    assign mul_a = PW'(req.node_a) * PW'(RECIP);
    assign mul_b = PW'(req.node_b) * PW'(RECIP);
    assign qd_a  = (2*NODE_W)'(qa_reg) * (2*NODE_W)'(NODES);
    assign qd_b  = (2*NODE_W)'(qb_reg) * (2*NODE_W)'(NODES);
    assign rem_a = raw_a_reg - qd_a[NODE_W-1:0];
    assign rem_b = raw_b_reg - qd_b[NODE_W-1:0];

    assign size_sum = lo_size_reg + s_rdata;
    assign root_ext = RW'(res_root_reg);
    assign size_ext = EW'(res_size_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == IW'(NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                state_next = ST_FSTART;
            end
            ST_FSTART:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (p_rdata == cur_reg)
                begin
                    state_next = (start_reg == cur_reg) ? ST_FDONE : ST_COMP;
                end
            end
            ST_COMP:
            begin
                if (p_rdata == rt_reg)
                begin
                    state_next = ST_FDONE;
                end
            end
            ST_FDONE:
            begin
                if (!phase_b_reg)
                begin
                    state_next = (kind_reg == KIND_FIND) ? ST_SZWAIT : ST_FSTART;
                end
                else
                begin
                    state_next = (ra_reg == rt_reg) ? ST_SZWAIT : ST_MHI;
                end
            end
            ST_MHI:
            begin
                state_next = ST_MADD;
            end
            ST_MADD:
            begin
                state_next = ST_RESULT;
            end
            ST_SZWAIT:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        kind_next       = kind_reg;
        raw_a_next      = raw_a_reg;
        raw_b_next      = raw_b_reg;
        qa_next         = qa_reg;
        qb_next         = qb_reg;
        idx_b_next      = idx_b_reg;
        start_next      = start_reg;
        cur_next        = cur_reg;
        rt_next         = rt_reg;
        ra_next         = ra_reg;
        phase_b_next    = phase_b_reg;
        hi_next         = hi_reg;
        lo_size_next    = lo_size_reg;
        res_root_next   = res_root_reg;
        res_joined_next = res_joined_reg;
        res_size_next   = res_size_reg;
        out_root_next   = out_root_reg;
        out_joined_next = out_joined_reg;
        out_size_next   = out_size_reg;

        p_we    = 1'b0;
        p_waddr = cur_reg;
        p_wdata = rt_reg;
        p_raddr = cur_reg;
        s_we    = 1'b0;
        s_waddr = hi_reg;
        s_wdata = size_sum;
        s_raddr = rt_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                p_we         = 1'b1;
                p_waddr      = clr_cnt_reg;
                p_wdata      = clr_cnt_reg;
                s_we         = 1'b1;
                s_waddr      = clr_cnt_reg;
                s_wdata      = SW'(1);
                clr_cnt_next = clr_cnt_reg + IW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = req.kind;
                    raw_a_next = req.node_a;
                    raw_b_next = req.node_b;
                    qa_next    = NODE_W'(mul_a >> RECIP_SHIFT);
                    qb_next    = NODE_W'(mul_b >> RECIP_SHIFT);
                end
            end
            ST_REDUCE:
            begin
                if (NEED_MOD)
                begin
                    idx_b_next = IW'(rem_b);
                    start_next = IW'(rem_a);
                end
                else
                begin
                    idx_b_next = IW'(raw_b_reg);
                    start_next = IW'(raw_a_reg);
                end
                phase_b_next = 1'b0;
            end
            ST_FSTART:
            begin
                p_raddr  = start_reg;
                cur_next = start_reg;
            end
            ST_WALK:
            begin
                if (p_rdata == cur_reg)
                begin
                    rt_next = cur_reg;
                    // restart at the first node for the compression pass
                    p_raddr  = start_reg;
                    cur_next = start_reg;
                end
                else
                begin
                    p_raddr  = p_rdata;
                    cur_next = p_rdata;
                end
            end
            ST_COMP:
            begin
                // point the current node at the root, fetch its old parent
                p_we     = 1'b1;
                p_raddr  = p_rdata;
                cur_next = p_rdata;
            end
            ST_FDONE:
            begin
                if (!phase_b_reg)
                begin
                    if (kind_reg == KIND_MERGE)
                    begin
                        ra_next      = rt_reg;
                        phase_b_next = 1'b1;
                        start_next   = idx_b_reg;
                    end
                end
                else if (ra_reg != rt_reg)
                begin
                    // hang the root with the smaller index under the one with the larger index
                    hi_next = (ra_reg < rt_reg) ? rt_reg : ra_reg;
                    p_we    = 1'b1;
                    p_waddr = (ra_reg < rt_reg) ? ra_reg : rt_reg;
                    p_wdata = (ra_reg < rt_reg) ? rt_reg : ra_reg;
                    s_raddr = (ra_reg < rt_reg) ? ra_reg : rt_reg;
                end
            end
            ST_MHI:
            begin
                lo_size_next = s_rdata;
                s_raddr      = hi_reg;
            end
            ST_MADD:
            begin
                s_we            = 1'b1;
                res_root_next   = hi_reg;
                res_joined_next = 1'b1;
                res_size_next   = size_sum;
            end
            ST_SZWAIT:
            begin
                res_root_next   = rt_reg;
                res_joined_next = 1'b0;
                res_size_next   = s_rdata;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_root_next   = root_ext[NODE_W-1:0];
                    out_joined_next = res_joined_reg;
                    out_size_next   = (size_ext > EW'(SIZE_OUT_MAX)) ?
                                      SIZE_W'(SIZE_OUT_MAX) : size_ext[SIZE_W-1:0];
                end
            end
            default:
            begin
                p_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        raw_a_reg      <= raw_a_next;
        raw_b_reg      <= raw_b_next;
        qa_reg         <= qa_next;
        qb_reg         <= qb_next;
        idx_b_reg      <= idx_b_next;
        start_reg      <= start_next;
        cur_reg        <= cur_next;
        rt_reg         <= rt_next;
        ra_reg         <= ra_next;
        phase_b_reg    <= phase_b_next;
        hi_reg         <= hi_next;
        lo_size_reg    <= lo_size_next;
        res_root_reg   <= res_root_next;
        res_joined_reg <= res_joined_next;
        res_size_reg   <= res_size_next;
        out_root_reg   <= out_root_next;
        out_joined_reg <= out_joined_next;
        out_size_reg   <= out_size_next;
    end

endmodule

// File: design/ufpc_checker.sv
`timescale 1ns / 1ps

module ufpc_checker import ufpc_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [NODE_W-1:0] rsp_root,
    input logic              rsp_joined,
    input logic [SIZE_W-1:0] rsp_set_size
);

    logic [1:0] pend_reg, pend_next;
    logic       req_fire, rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg + (req_fire ? 2'd1 : 2'd0) - (rsp_fire ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // hold a stalled result item
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_root)
            && $stable(rsp_joined) && $stable(rsp_set_size))
        else $error("stalled result item changed");

    // a join always leaves a set of at least two
    a_join_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_joined |-> rsp_set_size >= SIZE_W'(2))
        else $error("joined result with set size below two");

    // no result without an accepted item
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("result item without an accepted item");

    // at most one item at work besides one waiting result
    a_one_at_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |-> pend_reg < 2'd2)
        else $error("item accepted while another is still at work");

endmodule

bind union_find_path_compression ufpc_checker u_ufpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_root     (rsp.root),
    .rsp_joined   (rsp.joined),
    .rsp_set_size (rsp.set_size)
);
